/* design/i2crb_pkg.sv */
// Shared constants, codes and types for the I2C target register bridge.
`default_nettype none

package i2crb_pkg;

    // Register store entries and frame buffer bytes.
    localparam int REG_COUNT    = 64;
    localparam int BUFFER_BYTES = 128;

    localparam int REG_AW = $clog2(REG_COUNT);
    localparam int BUF_AW = $clog2(BUFFER_BYTES);
    // Frame length and transmit index must hold BUFFER_BYTES itself.
    localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);
    // Width for start address plus offset, and for length limit compares.
    localparam int SUM_W  = 9;

    localparam int WRITE_LIMIT_RESET = 60;
    localparam int REINIT_MASK_RESET = 1;

    typedef enum logic [2:0] {
        MODE_RX     = 3'd0,
        MODE_TXREQ  = 3'd1,
        MODE_NACK   = 3'd2,
        MODE_ADDR   = 3'd3,
        MODE_STOP   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ACK_NONE = 2'd0,
        ACK_EN   = 2'd1,
        ACK_DIS  = 2'd2
    } t_ack;

    typedef enum logic {
        CFG_WRITE_LIMIT = 1'b0,
        CFG_REINIT_MASK = 1'b1
    } t_cfg_idx;

    localparam logic [7:0] CMD_READ  = 8'd0;
    localparam logic [7:0] CMD_WRITE = 8'd1;

    // Packed so that tx_valid lands in bit 0 of the output word.
    typedef struct packed {
        logic       regs_written;
        logic       reinit_pending;
        logic [1:0] ack_action;
        logic [7:0] tx_byte;
        logic       tx_valid;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [BUF_AW-1:0] raddr;
    } t_buf_req;

    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [REG_AW-1:0] raddr;
    } t_reg_req;

endpackage

`default_nettype wire

/* design/i2crb_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module i2crb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/i2crb_ctrl.sv */
// Event sequencer: frame parsing, snapshot and commit copies over the two RAMs.
`default_nettype none

module i2crb_ctrl
    import i2crb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [2:0]  i_mode,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [6:0]  i_write_limit,
    input  wire logic [63:0] i_reinit_mask,
    output      t_buf_req    o_buf_req,
    input  wire logic [7:0]  i_buf_rdata,
    output      t_reg_req    o_reg_req,
    input  wire logic [7:0]  i_reg_rdata,
    output      logic        o_res_valid,
    input  wire logic        i_res_ready,
    output      t_result     o_res
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TXRD  = 7'b0000010,
        S_HDR   = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_CRD   = 7'b0010000,
        S_CWR   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state               r_state, n_state;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [LEN_W-1:0]     r_txi, n_txi;
    logic                 r_reinit, n_reinit;
    logic [REG_COUNT-1:0] r_reg_vld, n_reg_vld;

    logic                 r_is_rd, n_is_rd;
    logic [LEN_W-1:0]     r_cnt, n_cnt;
    logic [LEN_W-1:0]     r_n, n_n;
    logic [7:0]           r_b0, n_b0;
    logic [7:0]           r_a, n_a;
    logic [7:0]           r_b2, n_b2;
    logic [7:0]           r_first, n_first;
    logic                 r_src_ok, n_src_ok;
    t_result              r_res, n_res;

    logic [SUM_W-1:0]     sum;
    logic                 sum_in;
    logic [REG_AW-1:0]    reg_idx;
    logic [7:0]           copy_byte;
    logic                 last;

    assign sum       = {1'b0, r_a} + SUM_W'(r_cnt);
    assign sum_in    = sum < SUM_W'(REG_COUNT);
    assign reg_idx   = sum[REG_AW-1:0];
    assign copy_byte = r_src_ok ? i_reg_rdata : 8'd0;
    assign last      = (r_cnt == r_n - LEN_W'(1));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res                = r_res;
        o_res.reinit_pending = r_reinit;
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_txi     = r_txi;
        n_reinit  = r_reinit;
        n_reg_vld = r_reg_vld;
        n_is_rd   = r_is_rd;
        n_cnt     = r_cnt;
        n_n       = r_n;
        n_b0      = r_b0;
        n_a       = r_a;
        n_b2      = r_b2;
        n_first   = r_first;
        n_src_ok  = r_src_ok;
        n_res     = r_res;
        o_buf_req = '0;
        o_reg_req = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    case (i_mode)
                        MODE_RX: begin
                            if (r_len < LEN_W'(BUFFER_BYTES)) begin
                                o_buf_req.we    = 1'b1;
                                o_buf_req.waddr = r_len[BUF_AW-1:0];
                                o_buf_req.wdata = i_rx_byte;
                                n_len           = r_len + LEN_W'(1);
                            end
                        end
                        MODE_TXREQ: begin
                            if (r_len > r_txi) begin
                                o_buf_req.raddr = r_txi[BUF_AW-1:0];
                                n_state         = S_TXRD;
                            end else begin
                                // Snapshot used up: send zero and stop acknowledging.
                                n_len            = '0;
                                n_txi            = '0;
                                n_res.tx_valid   = 1'b1;
                                n_res.ack_action = ACK_DIS;
                            end
                        end
                        MODE_ADDR: begin
                            if (r_len == '0) begin
                                n_res.ack_action = ACK_EN;
                            end else if (r_len >= LEN_W'(3)) begin
                                o_buf_req.raddr = '0;
                                n_cnt           = '0;
                                n_is_rd         = 1'b1;
                                n_state         = S_HDR;
                            end
                        end
                        MODE_STOP: begin
                            if (r_len >= LEN_W'(3) &&
                                SUM_W'(r_len) < SUM_W'(3 + REG_COUNT)) begin
                                o_buf_req.raddr = '0;
                                n_cnt           = '0;
                                n_is_rd         = 1'b0;
                                n_state         = S_HDR;
                            end
                        end
                        MODE_NACK: begin
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_TXRD: begin
                n_res.tx_valid = 1'b1;
                n_res.tx_byte  = i_buf_rdata;
                n_txi          = r_txi + LEN_W'(1);
                n_state        = S_DONE;
            end

            S_HDR: begin
                // Capture command, address, then length; one read in flight.
                if (r_cnt == LEN_W'(0)) begin
                    n_b0 = i_buf_rdata;
                end else if (r_cnt == LEN_W'(1)) begin
                    n_a = i_buf_rdata;
                end else begin
                    n_b2 = i_buf_rdata;
                end
                if (r_cnt == LEN_W'(2)) begin
                    n_state = S_CHECK;
                end else begin
                    o_buf_req.raddr = BUF_AW'(r_cnt + LEN_W'(1));
                    n_cnt           = r_cnt + LEN_W'(1);
                end
            end

            S_CHECK: begin
                n_cnt   = '0;
                n_state = S_DONE;
                if (r_is_rd) begin
                    if (r_b0 == CMD_READ) begin
                        n_n = (r_b2 > 8'(BUFFER_BYTES)) ? LEN_W'(BUFFER_BYTES)
                                                          : LEN_W'(r_b2);
                        if (n_n == '0) begin
                            n_len          = '0;
                            n_txi          = LEN_W'(1);
                            n_res.tx_valid = 1'b1;
                        end else begin
                            n_state = S_CRD;
                        end
                    end
                end else if (r_b0 == CMD_WRITE) begin
                    if (r_a < {1'b0, i_write_limit}) begin
                        n_res.regs_written = 1'b1;
                        if (r_a[7:6] == 2'b00 && i_reinit_mask[r_a[5:0]]) begin
                            n_reinit = 1'b1;
                        end
                        n_n     = r_len - LEN_W'(2);
                        n_state = S_CRD;
                    end else begin
                        n_len = '0;
                    end
                end
            end

            S_CRD: begin
                if (r_is_rd) begin
                    o_reg_req.raddr = reg_idx;
                    n_src_ok        = sum_in && r_reg_vld[reg_idx];
                end else begin
                    o_buf_req.raddr = BUF_AW'(r_cnt + LEN_W'(2));
                    n_src_ok        = 1'b1;
                end
                n_state = S_CWR;
            end

            S_CWR: begin
                if (r_is_rd) begin
                    o_buf_req.we    = 1'b1;
                    o_buf_req.waddr = r_cnt[BUF_AW-1:0];
                    o_buf_req.wdata = copy_byte;
                    if (r_cnt == '0) begin
                        n_first = copy_byte;
                    end
                end else if (sum_in) begin
                    o_reg_req.we       = 1'b1;
                    o_reg_req.waddr    = reg_idx;
                    o_reg_req.wdata    = i_buf_rdata;
                    n_reg_vld[reg_idx] = 1'b1;
                end
                if (last) begin
                    n_state = S_DONE;
                    if (r_is_rd) begin
                        n_len          = r_n;
                        n_txi          = LEN_W'(1);
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = (r_cnt == '0) ? copy_byte : r_first;
                    end else begin
                        n_len = '0;
                    end
                end else begin
                    n_cnt   = r_cnt + LEN_W'(1);
                    n_state = S_CRD;
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_txi     <= '0;
            r_reinit  <= 1'b0;
            r_reg_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_txi     <= n_txi;
            r_reinit  <= n_reinit;
            r_reg_vld <= n_reg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_rd  <= n_is_rd;
        r_cnt    <= n_cnt;
        r_n      <= n_n;
        r_b0     <= n_b0;
        r_a      <= n_a;
        r_b2     <= n_b2;
        r_first  <= n_first;
        r_src_ok <= n_src_ok;
        r_res    <= n_res;
    end

endmodule

`default_nettype wire

/* design/i2c_target_register_bridge_top.sv */
// Top level: I2C target register bridge with stream ports and config writes.
// A received byte, nack, a transmit request with the snapshot used up, or a frame
//   turned away by its length goes straight to the result; a transmit request that
//   sends a buffered byte first reads the frame buffer; a frame whose header is read
//   goes through header read and check, and a read snapshot or committed write then
//   copies each byte as a read and then a write through the single read port of
//   each RAM.
// One event at a time: the next input word is accepted once the previous result
//   has moved into the output register.
// Reset (synchronous, active low) clears the sequencer, frame length, transmit
//   index, reinit flag and per-register valid bits, and loads write_limit = 60,
//   reinit_mask = 1. No clearing pass runs over the RAMs.
`default_nettype none

module i2c_target_register_bridge_top
    import i2crb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input word: [2:0] mode, [10:3] rx_byte, [15:11] zero
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,
    // Output word: [0] tx_valid, [8:1] tx_byte, [10:9] ack_action,
    //   [11] reinit_pending, [12] regs_written, [15:13] zero
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [15:0] m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [63:0] i_cfg_wdata
);

    logic [6:0]  r_write_limit;
    logic [63:0] r_reinit_mask;

    logic        r_out_valid;
    logic [15:0] r_out_data;

    t_buf_req    buf_req;
    t_reg_req    reg_req;
    logic [7:0]  buf_rdata;
    logic [7:0]  reg_rdata;
    logic        res_valid;
    logic        slot_free;
    t_result     res;

    // Configuration registers: user must have them written only while the bridge is idle; block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_limit <= 7'(WRITE_LIMIT_RESET);
            r_reinit_mask <= 64'(REINIT_MASK_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WRITE_LIMIT: r_write_limit <= i_cfg_wdata[6:0];
                CFG_REINIT_MASK: r_reinit_mask <= i_cfg_wdata;
                default: begin
                    r_write_limit <= r_write_limit;
                end
            endcase
        end
    end

    i2crb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_mode        (s_axis_tdata[2:0]),
        .i_rx_byte     (s_axis_tdata[10:3]),
        .i_write_limit (r_write_limit),
        .i_reinit_mask (r_reinit_mask),
        .o_buf_req     (buf_req),
        .i_buf_rdata   (buf_rdata),
        .o_reg_req     (reg_req),
        .i_reg_rdata   (reg_rdata),
        .o_res_valid   (res_valid),
        .i_res_ready   (slot_free),
        .o_res         (res)
    );

    // Frame buffer: received bytes, or the snapshot being transmitted.
    i2crb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (buf_req.we),
        .i_waddr (buf_req.waddr),
        .i_wdata (buf_req.wdata),
        .i_raddr (buf_req.raddr),
        .o_rdata (buf_rdata)
    );

    // Register store; entries never written read as zero via valid bits.
    i2crb_ram #(
        .WIDTH (8),
        .DEPTH (REG_COUNT)
    ) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (reg_req.we),
        .i_waddr (reg_req.waddr),
        .i_wdata (reg_req.wdata),
        .i_raddr (reg_req.raddr),
        .o_rdata (reg_rdata)
    );

    // Output register: takes a new result when empty or being drained.
    assign slot_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && slot_free) begin
            r_out_data <= {3'b000, res};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

/* design/i2crb_chk.sv */
// Port-level checker for the I2C target register bridge, bound to the top level.
`default_nettype none

module i2crb_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    logic r_seen_reinit;

    // Remember that a delivered word already reported the sticky flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_reinit <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[11]) begin
            r_seen_reinit <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_ack_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:9] != 2'b11)
        else $error("undefined acknowledge action");

    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
        else $error("nonzero byte without transmit");

    a_commit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |->
            !m_axis_tdata[0] && m_axis_tdata[10:9] == 2'b00)
        else $error("commit word also transmits or changes acknowledge");

    a_reinit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_seen_reinit |-> m_axis_tdata[11])
        else $error("reinit flag dropped after being reported");

endmodule

bind i2c_target_register_bridge_top i2crb_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the I2C target register bridge: stream stimulus, predictor, scoreboard.
module tb_top;
    import i2crb_pkg::*;

    // Stop the stimulus near this many non-ignored events per random phase.
    localparam int unsigned ITEMS_PER_PHASE = 205;
    localparam int unsigned RANDOM_PHASES   = 6;
    // Receiver hold-off: drop tready this long, once per this many accepted words.
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned HOLD_EVERY      = 350;
    // Longest block latency is a full snapshot of BUFFER_BYTES bytes.
    localparam int unsigned DRAIN_CYCLES    = 300;

    typedef struct packed {
        logic [7:0] rx;
        logic [2:0] mode;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [63:0] i_cfg_wdata = '0;

    i2c_target_register_bridge_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Shadow of the bridge: register store, frame buffer, pointers, sticky flag, config.
    logic [7:0]  store_bytes [REG_COUNT];
    logic [7:0]  frame_bytes [BUFFER_BYTES];
    int unsigned frame_fill;
    int unsigned send_pos;
    logic        reinit_seen;
    logic [6:0]  limit_reg;
    logic [63:0] mask_reg;

    // Event words waiting for the driver, and result words waiting for the block.
    t_event      pending_events [$];
    t_result     awaited_words [$];

    t_event      cur_event = '0;
    logic        offering = 1'b0;
    logic        gaps_on = 1'b1;
    int unsigned send_wait = 0;
    int unsigned ready_wait = 0;
    int unsigned events_sent = 0;
    int unsigned hold_left = 0;
    int unsigned next_hold_at = HOLD_EVERY;
    int unsigned queued_items = 0;
    int unsigned words_checked = 0;
    int unsigned failures = 0;
    int unsigned commits_seen = 0;
    int unsigned snapshots_taken = 0;
    int unsigned ack_drops = 0;
    t_result     got_word;
    t_result     want_word;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Apply one event to the shadow state and return the word the block must emit.
    function automatic t_result apply_event(input logic [2:0] mode, input logic [7:0] rx);
        t_result     res;
        int unsigned base;
        int unsigned span;
        int unsigned k;
        res = '0;
        case (mode)
            MODE_RX: begin
                // Drop the byte once the buffer is full.
                if (frame_fill < BUFFER_BYTES) begin
                    frame_bytes[frame_fill] = rx;
                    frame_fill++;
                end
            end
            MODE_TXREQ: begin
                res.tx_valid = 1'b1;
                if (frame_fill > send_pos && send_pos < BUFFER_BYTES) begin
                    res.tx_byte = frame_bytes[send_pos];
                    send_pos++;
                end else begin
                    // Snapshot used up: send zero, drop acknowledge, forget the frame.
                    res.ack_action = ACK_DIS;
                    frame_fill = 0;
                    send_pos = 0;
                end
            end
            MODE_ADDR: begin
                if (frame_fill == 0) begin
                    res.ack_action = ACK_EN;
                end else if (frame_fill >= 3 && frame_bytes[0] == CMD_READ) begin
                    base = frame_bytes[1];
                    span = frame_bytes[2];
                    if (span > BUFFER_BYTES)
                        span = BUFFER_BYTES;
                    for (k = 0; k < BUFFER_BYTES; k++)
                        frame_bytes[k] = (k < span && base + k < REG_COUNT) ?
                                         store_bytes[base + k] : 8'd0;
                    frame_fill = span;
                    res.tx_valid = 1'b1;
                    res.tx_byte = frame_bytes[0];
                    send_pos = 1;
                    snapshots_taken++;
                end
            end
            MODE_STOP: begin
                if (frame_fill >= 3 && frame_bytes[0] == CMD_WRITE &&
                    frame_fill < 3 + REG_COUNT) begin
                    base = frame_bytes[1];
                    if (base < limit_reg) begin
                        for (k = 0; k < frame_fill - 2; k++)
                            if (base + k < REG_COUNT)
                                store_bytes[base + k] = frame_bytes[2 + k];
                        res.regs_written = 1'b1;
                        if (base < $bits(mask_reg) && mask_reg[base])
                            reinit_seen = 1'b1;
                    end
                    // A well-formed write frame is consumed even when refused.
                    for (k = 0; k < frame_fill; k++)
                        frame_bytes[k] = 8'd0;
                    frame_fill = 0;
                end
            end
            default: ;
        endcase
        res.reinit_pending = reinit_seen;
        return res;
    endfunction

    task automatic queue_event(input logic [2:0] mode, input logic [7:0] rx);
        t_event ev;
        ev.mode = mode;
        ev.rx = rx;
        pending_events.push_back(ev);
        // Nack and the unused codes leave the block untouched; do not count them.
        if (mode != MODE_NACK && mode <= MODE_STOP)
            queued_items++;
    endtask

    // Issue enough transmit requests to run out any leftover frame of up to bound bytes.
    task automatic queue_drain(input int unsigned bound);
        repeat (bound + 1)
            queue_event(MODE_TXREQ, 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_write_frame(input logic [7:0] base, input int unsigned payload,
                                     input logic [7:0] cmd);
        queue_event(MODE_ADDR, 8'($urandom_range(0, 255)));
        queue_event(MODE_RX, cmd);
        queue_event(MODE_RX, base);
        repeat (payload)
            queue_event(MODE_RX, 8'($urandom_range(0, 255)));
        queue_event(MODE_STOP, 8'($urandom_range(0, 255)));
        // A frame the stop does not consume stays in the buffer; flush it.
        if (cmd != CMD_WRITE || payload == 0 || payload > REG_COUNT)
            queue_drain(payload + 2);
    endtask

    task automatic queue_read_frame(input logic [7:0] base, input logic [7:0] count,
                                    input bit partial);
        int unsigned avail;
        int unsigned sends;
        avail = (count > BUFFER_BYTES) ? BUFFER_BYTES : count;
        queue_event(MODE_RX, CMD_READ);
        queue_event(MODE_RX, base);
        queue_event(MODE_RX, count);
        // Either a stop then a fresh start, or a repeated start straight to the match.
        if ($urandom_range(0, 1) == 1)
            queue_event(MODE_STOP, 8'($urandom_range(0, 255)));
        queue_event(MODE_ADDR, 8'($urandom_range(0, 255)));
        sends = partial ? $urandom_range(0, avail) : ((avail == 0) ? 1 : avail);
        repeat (sends)
            queue_event(MODE_TXREQ, 8'($urandom_range(0, 255)));
        queue_event(MODE_NACK, 8'($urandom_range(0, 255)));
        queue_event(MODE_STOP, 8'($urandom_range(0, 255)));
        if (partial)
            queue_drain(avail);
    endtask

    // Start addresses: mostly inside the store, some at its end or at the write limit.
    function automatic logic [7:0] pick_base();
        int unsigned roll;
        int          limit_addr;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 8'($urandom_range(0, REG_COUNT - 1));
        if (roll < 80)
            return 8'($urandom_range(REG_COUNT - 4, REG_COUNT + 4));
        if (roll < 92) begin
            limit_addr = int'(limit_reg) + int'($urandom_range(0, 2)) - 1;
            return (limit_addr < 0) ? 8'd0 : 8'(limit_addr);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Gap lengths: mostly short, a few long.
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(40, 150);
    endfunction

    task automatic write_cfg(input t_cfg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        if (idx == CFG_WRITE_LIMIT)
            limit_reg = value[6:0];
        else
            mask_reg = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold the sender back until every queued event is in and every word is out.
    task automatic settle();
        while (pending_events.size() != 0 || offering || awaited_words.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Driver: present one event word at a time, predict it on acceptance, then maybe idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offering = 1'b0;
            s_axis_tvalid <= 1'b0;
        end else begin
            if (offering && s_axis_tready) begin
                awaited_words.push_back(apply_event(cur_event.mode, cur_event.rx));
                events_sent <= events_sent + 1;
                offering = 1'b0;
                if (gaps_on && $urandom_range(0, 2) == 0)
                    send_wait = idle_len();
            end
            // Advance to the next event only after the gap has run out.
            if (!offering) begin
                if (send_wait != 0) begin
                    send_wait--;
                end else if (pending_events.size() != 0) begin
                    cur_event = pending_events.pop_front();
                    offering = 1'b1;
                end
            end
            s_axis_tvalid <= offering;
            s_axis_tdata <= 16'({cur_event.rx, cur_event.mode});
        end
    end

    // Hold-off timer: stall the receiver for a long stretch every HOLD_EVERY events.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            next_hold_at <= HOLD_EVERY;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (events_sent >= next_hold_at) begin
            hold_left <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_EVERY;
        end
    end

    // Monitor: check each accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_word = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                if (awaited_words.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result word %h with nothing outstanding",
                                 m_axis_tdata);
                end else begin
                    want_word = awaited_words.pop_front();
                    words_checked++;
                    if (got_word.regs_written)
                        commits_seen++;
                    if (got_word.ack_action == ACK_DIS)
                        ack_drops++;
                    if (got_word.tx_valid !== want_word.tx_valid ||
                        got_word.tx_byte !== want_word.tx_byte ||
                        got_word.ack_action !== want_word.ack_action ||
                        got_word.reinit_pending !== want_word.reinit_pending ||
                        got_word.regs_written !== want_word.regs_written) begin
                        failures++;
                        if (failures <= 10)
                            $display({"word %0d mismatch: expected tx_valid=%0b tx_byte=%02h ",
                                      "ack=%0d reinit=%0b wrote=%0b, got tx_valid=%0b ",
                                      "tx_byte=%02h ack=%0d reinit=%0b wrote=%0b"},
                                     words_checked, want_word.tx_valid, want_word.tx_byte,
                                     want_word.ack_action, want_word.reinit_pending,
                                     want_word.regs_written, got_word.tx_valid,
                                     got_word.tx_byte, got_word.ack_action,
                                     got_word.reinit_pending, got_word.regs_written);
                    end
                end
            end
            // Drop tready during a hold-off or a random stall, else accept.
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else if (ready_wait != 0) begin
                ready_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (gaps_on && $urandom_range(0, 3) == 0)
                    ready_wait = idle_len();
            end
        end
    end

    // Stop a hung run.
    initial begin
        #(24_000_000);
        $display("i2c_target_register_bridge_top verification failed");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned goal;
        int unsigned roll;
        int unsigned burst;
        int unsigned fills;
        int unsigned payload;
        int unsigned count;
        logic [2:0]  pick;
        logic [7:0]  base;

        // Shadow state starts as the block does after reset.
        foreach (store_bytes[k])
            store_bytes[k] = 8'd0;
        foreach (frame_bytes[k])
            frame_bytes[k] = 8'd0;
        frame_fill = 0;
        send_pos = 0;
        reinit_seen = 1'b0;
        limit_reg = 7'(WRITE_LIMIT_RESET);
        mask_reg = 64'(REINIT_MASK_RESET);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset configuration (limit 60, mask bit 0 only).
        // Address match on an empty buffer enables acknowledge; a transmit request
        // with nothing to send returns zero and disables it.
        queue_event(MODE_ADDR, 8'hFF);
        queue_event(MODE_TXREQ, 8'h00);
        queue_event(MODE_NACK, 8'hAA);
        queue_event(MODE_STOP + 3'd1, 8'h55);
        // Write at the last register: above the write limit, so consumed but refused.
        queue_event(MODE_RX, CMD_WRITE);
        queue_event(MODE_RX, 8'(REG_COUNT - 1));
        queue_event(MODE_RX, 8'hA5);
        queue_event(MODE_RX, 8'h5A);
        queue_event(MODE_STOP, 8'h00);
        // Read across the end of the store: zeros past it, then run out the snapshot.
        queue_event(MODE_RX, CMD_READ);
        queue_event(MODE_RX, 8'(REG_COUNT - 2));
        queue_event(MODE_RX, 8'd3);
        queue_event(MODE_ADDR, 8'h00);
        queue_event(MODE_TXREQ, 8'hFF);
        queue_event(MODE_TXREQ, 8'h00);
        queue_event(MODE_TXREQ, 8'hFF);
        // Write at the limit is consumed but refused.
        queue_event(MODE_RX, CMD_WRITE);
        queue_event(MODE_RX, 8'(WRITE_LIMIT_RESET));
        queue_event(MODE_RX, 8'h77);
        queue_event(MODE_STOP, 8'hFF);
        // Write at address 0 hits the mask and raises the sticky reinit flag.
        queue_event(MODE_RX, CMD_WRITE);
        queue_event(MODE_RX, 8'd0);
        queue_event(MODE_RX, 8'h3C);
        queue_event(MODE_STOP, 8'h00);
        settle();

        for (phase = 1; phase <= RANDOM_PHASES; phase++) begin
            // Reconfigure only while idle; walk both registers through their extremes.
            case (phase)
                1: begin
                    write_cfg(CFG_WRITE_LIMIT, 64'(REG_COUNT));
                    write_cfg(CFG_REINIT_MASK, '1);
                end
                2: begin
                    write_cfg(CFG_WRITE_LIMIT, 64'd0);
                    write_cfg(CFG_REINIT_MASK, '0);
                end
                3: begin
                    write_cfg(CFG_WRITE_LIMIT, 64'($urandom_range(1, REG_COUNT - 1)));
                    write_cfg(CFG_REINIT_MASK, {$urandom, $urandom});
                end
                4: begin
                    write_cfg(CFG_REINIT_MASK, {$urandom, $urandom});
                    write_cfg(CFG_WRITE_LIMIT, 64'($urandom_range(1, REG_COUNT - 1)));
                end
                5: begin
                    write_cfg(CFG_WRITE_LIMIT, 64'(REG_COUNT));
                    write_cfg(CFG_REINIT_MASK, {$urandom, $urandom});
                end
                default: begin
                    write_cfg(CFG_WRITE_LIMIT, 64'($urandom_range(0, REG_COUNT)));
                    write_cfg(CFG_REINIT_MASK, '1);
                end
            endcase
            // One phase runs back to back on both sides.
            gaps_on = (phase != 2);
            goal = queued_items + ITEMS_PER_PHASE;

            if (phase == 3) begin
                // Overfill the buffer, flush it, then ask for more than it holds.
                repeat ($urandom_range(BUFFER_BYTES + 1, BUFFER_BYTES + 12))
                    queue_event(MODE_RX, 8'($urandom_range(0, 255)));
                queue_event(MODE_STOP, 8'($urandom_range(0, 255)));
                queue_drain(BUFFER_BYTES);
                queue_read_frame(pick_base(), 8'd255, 1'b0);
            end

            while (queued_items < goal) begin
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    payload = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6)
                                                           : $urandom_range(7, REG_COUNT);
                    queue_write_frame(pick_base(), payload, CMD_WRITE);
                end else if (roll < 80) begin
                    roll = $urandom_range(0, 99);
                    count = (roll < 90) ? $urandom_range(0, 8) :
                            (roll < 98) ? $urandom_range(9, 40) : $urandom_range(41, 255);
                    queue_read_frame(pick_base(), 8'(count), $urandom_range(0, 4) == 0);
                end else if (roll < 92) begin
                    // Noise: random events with random bytes, then flush what was stored.
                    // Leave address matches out so no snapshot can refill the buffer.
                    burst = $urandom_range(1, 10);
                    fills = 0;
                    repeat (burst) begin
                        pick = 3'($urandom_range(0, 7));
                        if (pick == MODE_ADDR)
                            pick = MODE_RX;
                        if (pick == MODE_RX)
                            fills++;
                        queue_event(pick, 8'($urandom_range(0, 255)));
                    end
                    queue_drain(fills);
                end else begin
                    base = pick_base();
                    case ($urandom_range(0, 3))
                        0: queue_write_frame(base, $urandom_range(1, 6),
                                             8'($urandom_range(CMD_WRITE + 1, 255)));
                        1: queue_write_frame(base, ($urandom_range(0, 1) == 1) ?
                                             REG_COUNT + 1 : 0, CMD_WRITE);
                        2: begin
                            // Read frame cut short before its length byte.
                            queue_event(MODE_RX, CMD_READ);
                            queue_event(MODE_RX, base);
                            queue_event(MODE_ADDR, 8'($urandom_range(0, 255)));
                            queue_event(MODE_STOP, 8'($urandom_range(0, 255)));
                            queue_drain(2);
                        end
                        default: begin
                            // Address match inside a write frame changes nothing.
                            queue_event(MODE_RX, CMD_WRITE);
                            queue_event(MODE_RX, base);
                            queue_event(MODE_RX, 8'($urandom_range(0, 255)));
                            queue_event(MODE_ADDR, 8'($urandom_range(0, 255)));
                            queue_event(MODE_STOP, 8'($urandom_range(0, 255)));
                        end
                    endcase
                end
            end
            settle();
        end

        gaps_on = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_words.size() != 0) begin
            failures++;
            $display("%0d predicted result words never arrived", awaited_words.size());
        end

        $display("run: %0d events over %0d configurations, %0d result words compared",
                 events_sent, RANDOM_PHASES + 1, words_checked);
        $display("seen: %0d register commits, %0d snapshots, %0d acknowledge drops",
                 commits_seen, snapshots_taken, ack_drops);
        if (failures == 0)
            $display("i2c_target_register_bridge_top verification clean");
        else
            $display("i2c_target_register_bridge_top verification failed");
        $finish;
    end

endmodule

/* filelist.f */
design/i2crb_pkg.sv
design/i2crb_ram.sv
design/i2crb_ctrl.sv
design/i2c_target_register_bridge_top.sv
design/i2crb_chk.sv
test/tb_top.sv
